/* design/rfsc_pkg.sv */
// Shared constants, types and helpers for the frustum sphere cull unit.
`default_nettype none

package rfsc_pkg;

    // Default coordinate width (signed Q12.8)
    localparam int COORD_WIDTH_DEFAULT = 20;

    // Fixed-point layout of the configuration fields
    localparam int AXIS_WIDTH      = 16;
    localparam int AXIS_FRAC       = 14;
    localparam int AXIS_PACK_WIDTH = 3 * AXIS_WIDTH;
    localparam int TAN_WIDTH       = 16;
    localparam int COORD_FRAC      = 8;

    // Register widths
    localparam int CAMERA_WIDTH  = 60;
    localparam int RANGE_WIDTH   = 40;
    localparam int FACTORS_WIDTH = 32;
    localparam int FIELD_WIDE    = 64;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = CAMERA_WIDTH;

    // Register stages from request to result
    localparam int PIPE_DEPTH = 7;

    // Indexes of the depth bounds carried from the projection stages
    localparam int BOUND_NEAR_LO = 0;  // near - radius
    localparam int BOUND_NEAR_HI = 1;  // near + radius
    localparam int BOUND_FAR_LO  = 2;  // far - radius
    localparam int BOUND_FAR_HI  = 3;  // far + radius
    localparam int BOUND_COUNT   = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CAMERA_POSITION    = 4'd0,
        REG_AXIS_FORWARD       = 4'd1,
        REG_AXIS_UP            = 4'd2,
        REG_AXIS_RIGHT         = 4'd3,
        REG_DEPTH_RANGE        = 4'd4,
        REG_TANGENT_VERTICAL   = 4'd5,
        REG_TANGENT_HORIZONTAL = 4'd6,
        REG_RADIUS_FACTORS     = 4'd7
    } reg_index_t;

    localparam int CONT_WIDTH = 2;

    typedef enum logic [CONT_WIDTH-1:0] {
        CONT_OUTSIDE = 2'd0,
        CONT_PARTIAL = 2'd1,
        CONT_INSIDE  = 2'd2
    } cont_t;

    typedef struct packed {
        logic [CAMERA_WIDTH-1:0]    camera_position;
        logic [AXIS_PACK_WIDTH-1:0] axis_forward;
        logic [AXIS_PACK_WIDTH-1:0] axis_up;
        logic [AXIS_PACK_WIDTH-1:0] axis_right;
        logic [RANGE_WIDTH-1:0]     depth_range;
        logic [TAN_WIDTH-1:0]       tangent_vertical;
        logic [TAN_WIDTH-1:0]       tangent_horizontal;
        logic [FACTORS_WIDTH-1:0]   radius_factors;
    } cfg_t;

    // Pick one signed Q1.14 component out of a packed x,y,z axis
    function automatic logic signed [AXIS_WIDTH-1:0] axis_comp(
        input logic [AXIS_PACK_WIDTH-1:0] axis,
        input int unsigned                k
    );
        return axis[k*AXIS_WIDTH +: AXIS_WIDTH];
    endfunction

endpackage

`default_nettype wire

/* design/rfsc_if.sv */
// Handshake channels of the frustum sphere cull unit: spheres, results, register writes.
`default_nettype none

interface rfsc_sphere_if #(
    parameter int COORD_WIDTH = rfsc_pkg::COORD_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] sphere_x;
    logic signed [COORD_WIDTH-1:0] sphere_y;
    logic signed [COORD_WIDTH-1:0] sphere_z;
    logic        [COORD_WIDTH-2:0] sphere_radius;

    modport source (output valid, output sphere_x, output sphere_y, output sphere_z,
                    output sphere_radius, input ready);
    modport sink   (input valid, input sphere_x, input sphere_y, input sphere_z,
                    input sphere_radius, output ready);
endinterface

interface rfsc_result_if;
    logic                            valid;
    logic                            ready;
    logic [rfsc_pkg::CONT_WIDTH-1:0] containment;

    modport source (output valid, output containment, input ready);
    modport sink   (input valid, input containment, output ready);
endinterface

interface rfsc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rfsc_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [rfsc_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/rfsc_cfg_regs.sv */
// Configuration register file of the frustum sphere cull unit.
`default_nettype none

module rfsc_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    rfsc_cfg_if.sink            cfg,
    output rfsc_pkg::cfg_t      cfg_val
);

    rfsc_pkg::cfg_t cfg_reg;
    rfsc_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    // Decode the register index, drop writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (rfsc_pkg::reg_index_t'(cfg.index))
                rfsc_pkg::REG_CAMERA_POSITION:
                    cfg_next.camera_position = cfg.data[rfsc_pkg::CAMERA_WIDTH-1:0];
                rfsc_pkg::REG_AXIS_FORWARD:
                    cfg_next.axis_forward = cfg.data[rfsc_pkg::AXIS_PACK_WIDTH-1:0];
                rfsc_pkg::REG_AXIS_UP:
                    cfg_next.axis_up = cfg.data[rfsc_pkg::AXIS_PACK_WIDTH-1:0];
                rfsc_pkg::REG_AXIS_RIGHT:
                    cfg_next.axis_right = cfg.data[rfsc_pkg::AXIS_PACK_WIDTH-1:0];
                rfsc_pkg::REG_DEPTH_RANGE:
                    cfg_next.depth_range = cfg.data[rfsc_pkg::RANGE_WIDTH-1:0];
                rfsc_pkg::REG_TANGENT_VERTICAL:
                    cfg_next.tangent_vertical = cfg.data[rfsc_pkg::TAN_WIDTH-1:0];
                rfsc_pkg::REG_TANGENT_HORIZONTAL:
                    cfg_next.tangent_horizontal = cfg.data[rfsc_pkg::TAN_WIDTH-1:0];
                rfsc_pkg::REG_RADIUS_FACTORS:
                    cfg_next.radius_factors = cfg.data[rfsc_pkg::FACTORS_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

/* design/rfsc_project.sv */
// Offset, dot-product and depth-bound stages (three register stages).
`default_nettype none

module rfsc_project #(
    parameter int COORD_WIDTH = rfsc_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire rfsc_pkg::cfg_t                             cfg_val,
    rfsc_sphere_if.sink                                     sphere,
    output logic                                            valid,
    input  wire logic                                       ready,
    output logic signed [COORD_WIDTH+18:0]                  depth,
    output logic signed [COORD_WIDTH+18:0]                  lat_y,
    output logic signed [COORD_WIDTH+18:0]                  lat_x,
    output logic        [COORD_WIDTH-2:0]                   radius,
    output logic signed [COORD_WIDTH+1:0]                   bounds [rfsc_pkg::BOUND_COUNT]
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;                         // offset
    localparam int PRW = DW + rfsc_pkg::AXIS_WIDTH;     // one product
    localparam int SW  = PRW + 2;                       // sum of three products
    localparam int BW  = W + 2;                         // depth bound
    localparam int FW  = rfsc_pkg::FIELD_WIDE;

    // Stage 1: offset from camera
    logic                 v1_reg;
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] d_next [3];
    logic [W-2:0]         rad1_reg;

    // Stage 2: nine products (forward, up, right by x, y, z)
    logic                  v2_reg;
    logic signed [PRW-1:0] prod_reg [3][3];
    logic signed [PRW-1:0] prod_next [3][3];
    logic [W-2:0]          rad2_reg;

    // Stage 3: projections and radius-adjusted depth limits
    logic                 v3_reg;
    logic signed [SW-1:0] depth_reg, lat_y_reg, lat_x_reg;
    logic signed [SW-1:0] depth_next, lat_y_next, lat_x_next;
    logic signed [BW-1:0] bound_reg  [rfsc_pkg::BOUND_COUNT];
    logic signed [BW-1:0] bound_next [rfsc_pkg::BOUND_COUNT];
    logic [W-2:0]         rad3_reg;

    logic rdy1, rdy2, rdy3;

    logic [FW-1:0]          cam_wide;
    logic [FW-1:0]          range_wide;
    logic [W-1:0]           sph [3];
    logic [W-1:0]           cam [3];
    logic [rfsc_pkg::AXIS_PACK_WIDTH-1:0] axes [3];
    logic signed [BW-1:0]   near_s, far_s, rad_s;

    // Ready ripples back so bubbles collapse
    assign rdy3         = !v3_reg || ready;
    assign rdy2         = !v2_reg || rdy3;
    assign rdy1         = !v1_reg || rdy2;
    assign sphere.ready = rdy1;

    assign cam_wide   = FW'(cfg_val.camera_position);
    assign range_wide = FW'(cfg_val.depth_range);
    assign sph[0]     = sphere.sphere_x;
    assign sph[1]     = sphere.sphere_y;
    assign sph[2]     = sphere.sphere_z;
    assign axes[0]    = cfg_val.axis_forward;
    assign axes[1]    = cfg_val.axis_up;
    assign axes[2]    = cfg_val.axis_right;

    // Subtract the camera position per component
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cam[k]    = cam_wide[k*W +: W];
            d_next[k] = $signed({sph[k][W-1], sph[k]}) - $signed({cam[k][W-1], cam[k]});
        end
    end

    // Multiply offsets by the axis components
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[a][k] = PRW'(d_reg[k])
                                * PRW'(rfsc_pkg::axis_comp(axes[a], k));
            end
        end
    end

    // Add products, form near/far limits moved by the radius
    always_comb
    begin
        near_s     = $signed({2'b00, range_wide[W-1:0]});
        far_s      = $signed({2'b00, range_wide[W +: W]});
        rad_s      = $signed({3'b000, rad2_reg});
        depth_next = SW'(prod_reg[0][0]) + SW'(prod_reg[0][1]) + SW'(prod_reg[0][2]);
        lat_y_next = SW'(prod_reg[1][0]) + SW'(prod_reg[1][1]) + SW'(prod_reg[1][2]);
        lat_x_next = SW'(prod_reg[2][0]) + SW'(prod_reg[2][1]) + SW'(prod_reg[2][2]);
        bound_next[rfsc_pkg::BOUND_NEAR_LO] = near_s - rad_s;
        bound_next[rfsc_pkg::BOUND_NEAR_HI] = near_s + rad_s;
        bound_next[rfsc_pkg::BOUND_FAR_LO]  = far_s - rad_s;
        bound_next[rfsc_pkg::BOUND_FAR_HI]  = far_s + rad_s;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= sphere.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // Advance payload with its valid bit
    always_ff @(posedge clk)
    begin
        if (rdy1 && sphere.valid)
        begin
            d_reg    <= d_next;
            rad1_reg <= sphere.sphere_radius;
        end
        if (rdy2 && v1_reg)
        begin
            prod_reg <= prod_next;
            rad2_reg <= rad1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            depth_reg <= depth_next;
            lat_y_reg <= lat_y_next;
            lat_x_reg <= lat_x_next;
            bound_reg <= bound_next;
            rad3_reg  <= rad2_reg;
        end
    end

    assign valid  = v3_reg;
    assign depth  = depth_reg;
    assign lat_y  = lat_y_reg;
    assign lat_x  = lat_x_reg;
    assign radius = rad3_reg;
    assign bounds = bound_reg;

endmodule

`default_nettype wire

/* design/rfsc_classify.sv */
// Depth test, field-of-view thresholds and containment result (four register stages).
`default_nettype none

module rfsc_classify #(
    parameter int COORD_WIDTH = rfsc_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rfsc_pkg::cfg_t                cfg_val,
    input  wire logic                          valid,
    output logic                               ready,
    input  wire logic signed [COORD_WIDTH+18:0] depth,
    input  wire logic signed [COORD_WIDTH+18:0] lat_y,
    input  wire logic signed [COORD_WIDTH+18:0] lat_x,
    input  wire logic        [COORD_WIDTH-2:0]  radius,
    input  wire logic signed [COORD_WIDTH+1:0]  bounds [rfsc_pkg::BOUND_COUNT],
    rfsc_result_if.source                      result
);

    localparam int W    = COORD_WIDTH;
    localparam int SW   = W + 19;                           // projection
    localparam int BW   = W + 2;                            // depth bound
    localparam int AF   = rfsc_pkg::AXIS_FRAC;
    localparam int CF   = rfsc_pkg::COORD_FRAC;
    localparam int PADB = SW - BW - AF;
    localparam int DRW  = (W - 1) + rfsc_pkg::TAN_WIDTH;    // radius * factor
    localparam int TW   = SW + rfsc_pkg::TAN_WIDTH;         // |depth| * tangent
    localparam int LW   = TW + 2;                           // signed limits

    // Stage 4: depth verdict, magnitudes, radius widening
    logic                  v4_reg;
    rfsc_pkg::cont_t       rz4_reg, rz4_next;
    logic [SW-1:0]         adepth4_reg, ay4_reg, ax4_reg;
    logic [SW-1:0]         adepth4_next, ay4_next, ax4_next;
    logic [DRW-1:0]        dry4_reg, drx4_reg;

    // Stage 5: depth-scaled thresholds
    logic                  v5_reg;
    rfsc_pkg::cont_t       rz5_reg;
    logic [SW-1:0]         ay5_reg, ax5_reg;
    logic [DRW-1:0]        dry5_reg, drx5_reg;
    logic [TW-1:0]         thy5_reg, thx5_reg;

    // Stage 6: widened and narrowed limits
    logic                  v6_reg;
    rfsc_pkg::cont_t       rz6_reg;
    logic [SW-1:0]         ay6_reg, ax6_reg;
    logic signed [LW-1:0]  upy6_reg, loy6_reg, upx6_reg, lox6_reg;
    logic signed [LW-1:0]  upy6_next, loy6_next, upx6_next, lox6_next;
    logic signed [LW-1:0]  thy_s, thx_s, dry_s, drx_s;

    // Stage 7: result register
    logic                  v7_reg;
    rfsc_pkg::cont_t       cont7_reg, cont7_next;
    rfsc_pkg::cont_t       ry, rx;
    logic signed [LW-1:0]  ay_s, ax_s;

    logic signed [SW-1:0]  near_lo_s, near_hi_s, far_lo_s, far_hi_s;
    logic                  zero_depth;
    logic [rfsc_pkg::TAN_WIDTH-1:0] fac_h, fac_v;

    logic rdy4, rdy5, rdy6, rdy7;

    // Ready ripples back so bubbles collapse
    assign rdy7         = !v7_reg || result.ready;
    assign rdy6         = !v6_reg || rdy7;
    assign rdy5         = !v5_reg || rdy6;
    assign rdy4         = !v4_reg || rdy5;
    assign ready        = rdy4;

    assign fac_h = cfg_val.radius_factors[rfsc_pkg::TAN_WIDTH-1:0];
    assign fac_v = cfg_val.radius_factors[rfsc_pkg::TAN_WIDTH +: rfsc_pkg::TAN_WIDTH];

    // Classify depth against the radius-moved near and far planes
    always_comb
    begin
        near_lo_s = $signed({{PADB{bounds[rfsc_pkg::BOUND_NEAR_LO][BW-1]}},
                             bounds[rfsc_pkg::BOUND_NEAR_LO], {AF{1'b0}}});
        near_hi_s = $signed({{PADB{bounds[rfsc_pkg::BOUND_NEAR_HI][BW-1]}},
                             bounds[rfsc_pkg::BOUND_NEAR_HI], {AF{1'b0}}});
        far_lo_s  = $signed({{PADB{bounds[rfsc_pkg::BOUND_FAR_LO][BW-1]}},
                             bounds[rfsc_pkg::BOUND_FAR_LO], {AF{1'b0}}});
        far_hi_s  = $signed({{PADB{bounds[rfsc_pkg::BOUND_FAR_HI][BW-1]}},
                             bounds[rfsc_pkg::BOUND_FAR_HI], {AF{1'b0}}});
        priority if (depth < near_lo_s || depth > far_hi_s)
            rz4_next = rfsc_pkg::CONT_OUTSIDE;
        else if (depth < near_hi_s || depth > far_lo_s)
            rz4_next = rfsc_pkg::CONT_PARTIAL;
        else
            rz4_next = rfsc_pkg::CONT_INSIDE;
    end

    // Take magnitudes; a zero depth zeroes both lateral offsets
    always_comb
    begin
        zero_depth   = (depth == '0);
        adepth4_next = depth[SW-1] ? SW'(-depth) : SW'(depth);
        if (zero_depth)
        begin
            ay4_next = '0;
            ax4_next = '0;
        end
        else
        begin
            ay4_next = lat_y[SW-1] ? SW'(-lat_y) : SW'(lat_y);
            ax4_next = lat_x[SW-1] ? SW'(-lat_x) : SW'(lat_x);
        end
    end

    // Widen and narrow the thresholds by the radius term
    always_comb
    begin
        thy_s = $signed(LW'(thy5_reg));
        thx_s = $signed(LW'(thx5_reg));
        dry_s = $signed({{(LW-DRW-AF){1'b0}}, dry5_reg, {AF{1'b0}}});
        drx_s = $signed({{(LW-DRW-AF){1'b0}}, drx5_reg, {AF{1'b0}}});
        upy6_next = thy_s + dry_s;
        loy6_next = thy_s - dry_s;
        upx6_next = thx_s + drx_s;
        lox6_next = thx_s - drx_s;
    end

    // Compare lateral magnitudes and merge the three verdicts
    always_comb
    begin
        ay_s = $signed({{(LW-SW-CF){1'b0}}, ay6_reg, {CF{1'b0}}});
        ax_s = $signed({{(LW-SW-CF){1'b0}}, ax6_reg, {CF{1'b0}}});
        priority if (ay_s > upy6_reg)
            ry = rfsc_pkg::CONT_OUTSIDE;
        else if (ay_s > loy6_reg)
            ry = rfsc_pkg::CONT_PARTIAL;
        else
            ry = rfsc_pkg::CONT_INSIDE;
        priority if (ax_s > upx6_reg)
            rx = rfsc_pkg::CONT_OUTSIDE;
        else if (ax_s > lox6_reg)
            rx = rfsc_pkg::CONT_PARTIAL;
        else
            rx = rfsc_pkg::CONT_INSIDE;
        priority if (rz6_reg == rfsc_pkg::CONT_OUTSIDE || ry == rfsc_pkg::CONT_OUTSIDE
                     || rx == rfsc_pkg::CONT_OUTSIDE)
            cont7_next = rfsc_pkg::CONT_OUTSIDE;
        else if (rz6_reg == rfsc_pkg::CONT_INSIDE && ry == rfsc_pkg::CONT_INSIDE
                 && rx == rfsc_pkg::CONT_INSIDE)
            cont7_next = rfsc_pkg::CONT_INSIDE;
        else
            cont7_next = rfsc_pkg::CONT_PARTIAL;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                v4_reg <= valid;
            if (rdy5)
                v5_reg <= v4_reg;
            if (rdy6)
                v6_reg <= v5_reg;
            if (rdy7)
                v7_reg <= v6_reg;
        end
    end

    // Advance payload with its valid bit
    always_ff @(posedge clk)
    begin
        if (rdy4 && valid)
        begin
            rz4_reg     <= rz4_next;
            adepth4_reg <= adepth4_next;
            ay4_reg     <= ay4_next;
            ax4_reg     <= ax4_next;
            dry4_reg    <= DRW'(radius) * DRW'(fac_v);
            drx4_reg    <= DRW'(radius) * DRW'(fac_h);
        end
        if (rdy5 && v4_reg)
        begin
            rz5_reg  <= rz4_reg;
            ay5_reg  <= ay4_reg;
            ax5_reg  <= ax4_reg;
            dry5_reg <= dry4_reg;
            drx5_reg <= drx4_reg;
            thy5_reg <= TW'(adepth4_reg) * TW'(cfg_val.tangent_vertical);
            thx5_reg <= TW'(adepth4_reg) * TW'(cfg_val.tangent_horizontal);
        end
        if (rdy6 && v5_reg)
        begin
            rz6_reg  <= rz5_reg;
            ay6_reg  <= ay5_reg;
            ax6_reg  <= ax5_reg;
            upy6_reg <= upy6_next;
            loy6_reg <= loy6_next;
            upx6_reg <= upx6_next;
            lox6_reg <= lox6_next;
        end
        if (rdy7 && v6_reg)
            cont7_reg <= cont7_next;
    end

    assign result.valid       = v7_reg;
    assign result.containment = cont7_reg;

endmodule

`default_nettype wire

/* design/radar_frustum_sphere_cull_unit.sv */
// Top level of the frustum sphere cull unit.
// Tests one bounding sphere per clock against the view frustum and returns 0 (fully
// outside), 1 (partly inside) or 2 (fully inside). The unit is a seven-stage pipeline:
// offset, nine axis products, three dot-product sums with near/far limits, depth verdict
// and magnitudes, threshold multiplies, threshold widening, and the result register.
// A new request is taken every cycle unless a full pipeline stalls on the result side;
// the pipeline depth is set by the multiply and add chain of the dot products and the
// depth-scaled thresholds. A stall on the result side fills empty stages first, so
// up to seven requests stay in flight. Register writes are always taken and act at
// once; write them only while no sphere is in flight.
`default_nettype none

module radar_frustum_sphere_cull_unit #(
    parameter int COORD_WIDTH = rfsc_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rfsc_sphere_if.sink      sphere,
    rfsc_result_if.source    result,
    rfsc_cfg_if.sink         cfg
);

    rfsc_pkg::cfg_t                 cfg_val;
    logic                           proj_valid;
    logic                           proj_ready;
    logic signed [COORD_WIDTH+18:0] depth;
    logic signed [COORD_WIDTH+18:0] lat_y;
    logic signed [COORD_WIDTH+18:0] lat_x;
    logic        [COORD_WIDTH-2:0]  radius;
    logic signed [COORD_WIDTH+1:0]  bounds [rfsc_pkg::BOUND_COUNT];

    rfsc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    rfsc_project #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_project (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_val),
        .sphere  (sphere),
        .valid   (proj_valid),
        .ready   (proj_ready),
        .depth   (depth),
        .lat_y   (lat_y),
        .lat_x   (lat_x),
        .radius  (radius),
        .bounds  (bounds)
    );

    rfsc_classify #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_val),
        .valid   (proj_valid),
        .ready   (proj_ready),
        .depth   (depth),
        .lat_y   (lat_y),
        .lat_x   (lat_x),
        .radius  (radius),
        .bounds  (bounds),
        .result  (result)
    );

endmodule

`default_nettype wire

/* design/rfsc_checker.sv */
// Port-level checks of the frustum sphere cull unit and their bind to the top level.
`default_nettype none

module rfsc_checker #(
    parameter int MAX_IN_FLIGHT = rfsc_pkg::PIPE_DEPTH
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [rfsc_pkg::CONT_WIDTH-1:0] containment
);

    localparam int CW = $clog2(MAX_IN_FLIGHT + 2);

    logic [CW-1:0] pend_reg;
    logic [CW-1:0] pend_next;

    // Count requests taken but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_valid && in_ready)
            pend_next = pend_next + CW'(1);
        if (out_valid && out_ready)
            pend_next = pend_next - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result shown with no request in flight");

    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CW'(MAX_IN_FLIGHT))
        else $error("more requests in flight than pipeline stages");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("request refused while the result side is ready");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(containment))
        else $error("stalled result changed or dropped");

endmodule

bind radar_frustum_sphere_cull_unit rfsc_checker u_rfsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sphere.valid),
    .in_ready    (sphere.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .containment (result.containment)
);

`default_nettype wire

/* bench/tb_radar_frustum_sphere_cull_unit.sv */
// Self-checking testbench: frustum sphere cull unit against an exact fixed-point predictor.
`timescale 1ns / 1ps

module tb_radar_frustum_sphere_cull_unit;
    import rfsc_pkg::*;

    localparam int CW              = COORD_WIDTH_DEFAULT;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 64;
    localparam int QUIET_LIMIT     = 2000;
    localparam int MAX_PRINTS      = 50;

    // Scale steps between the fixed-point formats
    localparam longint AXIS_ONE  = 64'sd1 << AXIS_FRAC;
    localparam longint COORD_ONE = 64'sd1 << COORD_FRAC;

    // Unit axes, Q1.14, and the first index past the register list
    localparam logic [AXIS_PACK_WIDTH-1:0] UNIT_X = 48'h0000_0000_4000;
    localparam logic [AXIS_PACK_WIDTH-1:0] UNIT_Y = 48'h0000_4000_0000;
    localparam logic [AXIS_PACK_WIDTH-1:0] UNIT_Z = 48'h4000_0000_0000;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_FIRST =
        CFG_INDEX_WIDTH'(REG_RADIUS_FACTORS) + 1'b1;

    localparam logic signed [CW-1:0] C_MAX = 20'sh7FFFF;
    localparam logic signed [CW-1:0] C_MIN = 20'sh80000;
    localparam logic [CW-2:0]        R_MAX = 19'h7FFFF;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [CW-2:0]        radius;
    } sphere_t;

    typedef struct packed {
        bit                   nominal;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [CW-2:0]        radius;
        bit                   fixed;
        cont_t                want;
    } sphere_row_t;

    // Rows under reset settings carry their verdict; nominal-view rows go to the predictor.
    // Nominal view: camera at origin, forward +z, up +y, right +x, near 1.0, far 100.0,
    // tangents 1.0, radius factors 1.0.
    localparam int DIRECTED_COUNT = 22;
    localparam sphere_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{1'b0, C_MAX, C_MAX, C_MAX, 19'd0, 1'b1, CONT_INSIDE},
        '{1'b0, C_MIN, C_MIN, C_MIN, R_MAX, 1'b1, CONT_PARTIAL},
        '{1'b0, 20'sd0, 20'sd0, 20'sd0, 19'd0, 1'b1, CONT_INSIDE},
        '{1'b0, C_MIN, C_MAX, 20'sd0, 19'd1, 1'b1, CONT_PARTIAL},
        '{1'b0, -20'sd1, -20'sd1, -20'sd1, R_MAX, 1'b1, CONT_PARTIAL},
        // in view, behind the camera
        '{1'b1, 20'sd0, 20'sd0, 20'sd2560, 19'd256, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd0, 20'sd0, -20'sd2560, 19'd256, 1'b0, CONT_OUTSIDE},
        // zero depth: lateral axes cannot reject
        '{1'b1, 20'sd1000, -20'sd1000, 20'sd0, 19'd0, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd1000, -20'sd1000, 20'sd0, 19'd512, 1'b0, CONT_OUTSIDE},
        // depth exactly on widened and narrowed near/far limits
        '{1'b1, 20'sd0, 20'sd0, 20'sd128, 19'd128, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd0, 20'sd0, 20'sd384, 19'd128, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd0, 20'sd0, 20'sd25856, 19'd256, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd0, 20'sd0, 20'sd25857, 19'd256, 1'b0, CONT_OUTSIDE},
        // lateral offsets on and past the widened limit, and on the narrowed one
        '{1'b1, 20'sd0, 20'sd2816, 20'sd2560, 19'd256, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd0, 20'sd2817, 20'sd2560, 19'd256, 1'b0, CONT_OUTSIDE},
        '{1'b1, -20'sd2304, 20'sd2304, 20'sd2560, 19'd256, 1'b0, CONT_OUTSIDE},
        '{1'b1, -20'sd2817, 20'sd0, 20'sd2560, 19'd256, 1'b0, CONT_OUTSIDE},
        // negative depth flips the lateral sign
        '{1'b1, 20'sd0, 20'sd5000, -20'sd1000, 19'd0, 1'b0, CONT_OUTSIDE},
        '{1'b1, C_MAX, C_MAX, C_MAX, R_MAX, 1'b0, CONT_OUTSIDE},
        '{1'b1, C_MIN, C_MIN, C_MIN, 19'd0, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd0, 20'sd0, 20'sd2560, R_MAX, 1'b0, CONT_OUTSIDE},
        '{1'b1, 20'sd0, 20'sd0, C_MAX, 19'd0, 1'b0, CONT_OUTSIDE}
    };

    logic clk = 1'b0;
    logic rst_n;

    rfsc_sphere_if #(.COORD_WIDTH(CW)) sph_ch ();
    rfsc_result_if                     res_ch ();
    rfsc_cfg_if                        cfg_ch ();

    radar_frustum_sphere_cull_unit #(
        .COORD_WIDTH(CW)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sphere (sph_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Free-running clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    cfg_t  shadow_cfg = '0;
    cont_t verdict_queue [$];
    int    error_count    = 0;
    int    send_idle_pct  = 13;
    int    recv_idle_pct  = 49;
    bit    hold_requested = 1'b0;

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offset (8 frac bits) dotted with a packed Q1.14 axis: 22 frac bits
    function automatic longint axis_dot(input longint ox, input longint oy, input longint oz,
                                        input logic [AXIS_PACK_WIDTH-1:0] axis);
        longint ax, ay, az;
        ax = longint'($signed(axis[0 +: AXIS_WIDTH]));
        ay = longint'($signed(axis[AXIS_WIDTH +: AXIS_WIDTH]));
        az = longint'($signed(axis[2*AXIS_WIDTH +: AXIS_WIDTH]));
        return ox * ax + oy * ay + oz * az;
    endfunction

    // Lateral test at 30 frac bits; zero depth collapses value and threshold to zero
    function automatic cont_t side_verdict(input longint proj, input longint depth,
                                           input logic [TAN_WIDTH-1:0] tangent,
                                           input logic [TAN_WIDTH-1:0] factor,
                                           input longint rad);
        longint sgn, adepth, thr, dr, v;
        sgn    = (depth > 0) ? 64'sd1 : ((depth < 0) ? -64'sd1 : 64'sd0);
        adepth = (depth < 0) ? -depth : depth;
        thr    = adepth * longint'(tangent);
        dr     = rad * longint'(factor) * AXIS_ONE;
        v      = proj * sgn * COORD_ONE;
        if (v > thr + dr || v < -thr - dr)
            return CONT_OUTSIDE;
        if (v > thr - dr || v < -thr + dr)
            return CONT_PARTIAL;
        return CONT_INSIDE;
    endfunction

    function automatic cont_t cull_predict(input sphere_t s, input cfg_t c);
        longint ox, oy, oz, rad, depth, py, px, near_q, far_q, r22;
        cont_t  rz, ry, rx;
        ox  = longint'(s.x) - longint'($signed(c.camera_position[0 +: CW]));
        oy  = longint'(s.y) - longint'($signed(c.camera_position[CW +: CW]));
        oz  = longint'(s.z) - longint'($signed(c.camera_position[2*CW +: CW]));
        rad = longint'(s.radius);

        depth  = axis_dot(ox, oy, oz, c.axis_forward);
        py     = axis_dot(ox, oy, oz, c.axis_up);
        px     = axis_dot(ox, oy, oz, c.axis_right);
        near_q = longint'(c.depth_range[0 +: CW]) * AXIS_ONE;
        far_q  = longint'(c.depth_range[CW +: CW]) * AXIS_ONE;
        r22    = rad * AXIS_ONE;

        // Depth against near/far, widened for outside and narrowed for inside
        if (depth < near_q - r22 || depth > far_q + r22)
            rz = CONT_OUTSIDE;
        else if (depth < near_q + r22 || depth > far_q - r22)
            rz = CONT_PARTIAL;
        else
            rz = CONT_INSIDE;

        ry = side_verdict(py, depth, c.tangent_vertical,
                          c.radius_factors[TAN_WIDTH +: TAN_WIDTH], rad);
        rx = side_verdict(px, depth, c.tangent_horizontal,
                          c.radius_factors[0 +: TAN_WIDTH], rad);

        if (rz == CONT_OUTSIDE || ry == CONT_OUTSIDE || rx == CONT_OUTSIDE)
            return CONT_OUTSIDE;
        if (rz == CONT_INSIDE && ry == CONT_INSIDE && rx == CONT_INSIDE)
            return CONT_INSIDE;
        return CONT_PARTIAL;
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] raw_word();
        return CFG_DATA_WIDTH'({$urandom, $urandom});
    endfunction

    // Mostly spheres around the camera at a random scale, the rest fully random
    function automatic sphere_t draw_sphere();
        sphere_t          s;
        int               sh;
        logic [CW-1:0]    cx, cy, cz;
        cx = shadow_cfg.camera_position[0 +: CW];
        cy = shadow_cfg.camera_position[CW +: CW];
        cz = shadow_cfg.camera_position[2*CW +: CW];
        if ($urandom_range(3) == 0)
        begin
            s.x      = CW'($urandom);
            s.y      = CW'($urandom);
            s.z      = CW'($urandom);
            s.radius = (CW-1)'($urandom);
        end
        else
        begin
            sh       = 6 + 3 * $urandom_range(3);
            s.x      = cx + CW'($urandom_range(2 << sh)) - CW'(1 << sh);
            s.y      = cy + CW'($urandom_range(2 << sh)) - CW'(1 << sh);
            s.z      = cz + CW'($urandom_range(2 << sh)) - CW'(1 << sh);
            s.radius = (CW-1)'($urandom_range(1 << (sh - 1)));
        end
        return s;
    endfunction

    // Hold the write until it is taken, then mirror it into the shadow copy
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_CAMERA_POSITION:    shadow_cfg.camera_position    = val[CAMERA_WIDTH-1:0];
            REG_AXIS_FORWARD:       shadow_cfg.axis_forward       = val[AXIS_PACK_WIDTH-1:0];
            REG_AXIS_UP:            shadow_cfg.axis_up            = val[AXIS_PACK_WIDTH-1:0];
            REG_AXIS_RIGHT:         shadow_cfg.axis_right         = val[AXIS_PACK_WIDTH-1:0];
            REG_DEPTH_RANGE:        shadow_cfg.depth_range        = val[RANGE_WIDTH-1:0];
            REG_TANGENT_VERTICAL:   shadow_cfg.tangent_vertical   = val[TAN_WIDTH-1:0];
            REG_TANGENT_HORIZONTAL: shadow_cfg.tangent_horizontal = val[TAN_WIDTH-1:0];
            REG_RADIUS_FACTORS:     shadow_cfg.radius_factors     = val[FACTORS_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Write every register, plus one index past the list that must be ignored
    task automatic program_settings(input logic [CFG_DATA_WIDTH-1:0] cam,
                                    input logic [CFG_DATA_WIDTH-1:0] fwd,
                                    input logic [CFG_DATA_WIDTH-1:0] up,
                                    input logic [CFG_DATA_WIDTH-1:0] right,
                                    input logic [CFG_DATA_WIDTH-1:0] range,
                                    input logic [CFG_DATA_WIDTH-1:0] tan_v,
                                    input logic [CFG_DATA_WIDTH-1:0] tan_h,
                                    input logic [CFG_DATA_WIDTH-1:0] factors);
        write_reg(REG_CAMERA_POSITION, cam);
        write_reg(REG_AXIS_FORWARD, fwd);
        write_reg(REG_AXIS_UP, up);
        write_reg(REG_AXIS_RIGHT, right);
        write_reg(REG_DEPTH_RANGE, range);
        write_reg(REG_TANGENT_VERTICAL, tan_v);
        write_reg(REG_TANGENT_HORIZONTAL, tan_h);
        write_reg(REG_RADIUS_FACTORS, factors);
        write_reg(CFG_INDEX_WIDTH'($urandom_range(2**CFG_INDEX_WIDTH - 1, CFG_SPARE_FIRST)),
                  raw_word());
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_nominal();
        program_settings('0, UNIT_Z, UNIT_Y, UNIT_X, {20'd25600, 20'd256},
                         16'd256, 16'd256, {16'd256, 16'd256});
    endtask

    // Orthogonal unit axes with random signs, camera and view limits at moderate values
    task automatic program_view_random();
        logic [AXIS_PACK_WIDTH-1:0] ax [3];
        logic [CAMERA_WIDTH-1:0]    cam;
        int                         f, u, r, k;
        int unsigned                near_v, far_v;
        for (k = 0; k < 3; k++)
        begin
            ax[k] = '0;
            ax[k][k*AXIS_WIDTH +: AXIS_WIDTH] = $urandom_range(1) ? 16'h4000 : 16'hC000;
            cam[k*CW +: CW] = CW'($urandom_range(1 << 19) - (1 << 18));
        end
        f = $urandom_range(2);
        u = (f + 1 + $urandom_range(1)) % 3;
        r = 3 - f - u;
        near_v = $urandom_range(1024);
        // occasionally an inverted range
        far_v = ($urandom_range(9) == 0) ? $urandom_range(near_v) : $urandom_range(20000, near_v);
        program_settings(cam, ax[f], ax[u], ax[r], {CW'(far_v), CW'(near_v)},
                         $urandom_range(768), $urandom_range(768),
                         {16'($urandom_range(768)), 16'($urandom_range(768))});
    endtask

    // Offer one sphere with random idle gaps; record its verdict once it is taken
    task automatic offer_sphere(input sphere_t s, input bit fixed, input cont_t fixed_want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sph_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sph_ch.valid         <= 1'b1;
        sph_ch.sphere_x      <= s.x;
        sph_ch.sphere_y      <= s.y;
        sph_ch.sphere_z      <= s.z;
        sph_ch.sphere_radius <= s.radius;
        @(posedge clk);
        while (!sph_ch.ready)
            @(posedge clk);
        verdict_queue.push_back(fixed ? fixed_want : cull_predict(s, shadow_cfg));
    endtask

    // Wait for every outstanding verdict, then let the pipeline run dry
    task automatic settle();
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int    hold_left;
        bit    go;
        cont_t want;
        hold_left = 0;
        forever
        begin
            if (hold_requested)
            begin
                hold_requested = 1'b0;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                go = 1'b0;
                hold_left--;
            end
            else
                go = ($urandom_range(99) >= recv_idle_pct);
            res_ch.ready <= go;
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (verdict_queue.size() == 0)
                    report_error($sformatf("unexpected result %0d", res_ch.containment));
                else
                begin
                    want = verdict_queue.pop_front();
                    if (res_ch.containment !== want)
                        report_error($sformatf("containment %0d, predicted %0d",
                                               res_ch.containment, want));
                end
            end
        end
    end

    // End the run if nothing moves on any channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sph_ch.valid && sph_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        sphere_row_t row;
        sphere_t     s;
        bit          nominal_on;
        int          i, phase, n;

        rst_n                <= 1'b0;
        sph_ch.valid         <= 1'b0;
        sph_ch.sphere_x      <= '0;
        sph_ch.sphere_y      <= '0;
        sph_ch.sphere_z      <= '0;
        sph_ch.sphere_radius <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        nominal_on = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: reset settings first, then the nominal view
        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.nominal && !nominal_on)
            begin
                sph_ch.valid <= 1'b0;
                settle();
                program_nominal();
                nominal_on = 1'b1;
            end
            s.x      = row.x;
            s.y      = row.y;
            s.z      = row.z;
            s.radius = row.radius;
            offer_sphere(s, row.fixed, row.want);
        end

        // Random phases, each under its own settings; the idling mode changes every two phases
        for (phase = 0; phase < PHASES; phase++)
        begin
            sph_ch.valid <= 1'b0;
            settle();
            send_idle_pct = (phase < 2) ? 13 : ((phase < 4) ? 49 : 0);
            recv_idle_pct = (phase < 2) ? 49 : ((phase < 4) ? 13 : 0);
            case (phase)
                0: program_nominal();
                2: program_settings('1, '1, '1, '1, '1, '1, '1, '1);
                3: program_settings(raw_word(), raw_word(), raw_word(), raw_word(),
                                    raw_word(), raw_word(), raw_word(), raw_word());
                4: program_settings('0, '0, '0, '0, '0, '0, '0, '0);
                default: program_view_random();
            endcase
            if (phase == 0 || phase == 5)
                hold_requested = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                offer_sphere(draw_sphere(), 1'b0, CONT_OUTSIDE);
        end

        sph_ch.valid <= 1'b0;
        settle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
